FILE: hw/rtl/eci_pkg.sv
// Shared widths, types, codes and the Q7.16 product helper of the easing
// curve interpolator. No dependencies.
`default_nettype none

package eci_pkg;

  // Field widths
  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned TIME_BITS  = 16;
  // Progress is an unsigned Q0.16 fraction
  localparam int unsigned PBITS      = 16;
  // Width of eased-progress and polynomial values (signed Q7.16)
  localparam int unsigned FX_W       = 24;

  // Curve pipeline register stages before its output register
  localparam int unsigned CV_STAGES  = 10;
  // Register stages from input transfer to result: launch, divider, curve, blend
  localparam int unsigned PIPE_DEPTH = 1 + PBITS + CV_STAGES + 1 + 2;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = TIME_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE     = 2'd0,
    CFG_DURATION = 2'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    MODE_LINEAR   = 3'd0,
    MODE_QUAD_IN  = 3'd1,
    MODE_QUAD_OUT = 3'd2,
    MODE_BOUNCE   = 3'd3,
    MODE_ELASTIC  = 3'd4,
    MODE_BACK_IN  = 3'd5,
    MODE_BACK_OUT = 3'd6,
    MODE_UNKNOWN  = 3'd7
  } mode_e;

  typedef logic signed [FX_W-1:0] fx_t;

  // Item payload carried along the pipeline
  typedef struct packed {
    logic signed [VALUE_BITS-1:0] start;
    logic signed [VALUE_BITS-1:0] change;
    logic                         fin;
  } item_t;

  localparam fx_t Q_ONE = fx_t'(65536);

  localparam logic signed [2*FX_W-1:0] MUL_RND = (2*FX_W)'(32768);

  // Q16 product, rounded to nearest with ties toward plus infinity
  function automatic fx_t mulq(input fx_t a, input fx_t b);
    logic signed [2*FX_W-1:0] prod;
    prod = a * b;
    prod = prod + MUL_RND;
    return fx_t'(prod >>> 16);
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/eci_divider.sv
// Pipelined restoring divider: progress = floor(elapsed * 2^16 / duration),
// for elapsed below duration, one quotient bit per stage. Depends on eci_pkg.
`default_nettype none

module eci_divider (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  input  wire logic [eci_pkg::TIME_BITS-1:0]  elapsed_i,
  input  wire logic [eci_pkg::TIME_BITS-1:0]  duration_i,
  input  wire eci_pkg::item_t                 item_i,
  output logic                                out_valid_o,
  output logic [eci_pkg::PBITS-1:0]           p_o,
  output eci_pkg::item_t                      item_o
);

  localparam int unsigned TB = eci_pkg::TIME_BITS;
  localparam int unsigned PB = eci_pkg::PBITS;

  logic                vld_q [0:PB];
  logic [TB-1:0]       rem_q [0:PB];
  logic [PB-1:0]       quo_q [0:PB];
  eci_pkg::item_t      itm_q [0:PB];

  logic [TB:0]         dbl   [1:PB];
  logic [TB:0]         dif   [1:PB];
  logic                ge    [1:PB];
  logic [TB-1:0]       rem_d [1:PB];
  logic [PB-1:0]       quo_d [1:PB];

  // Trial subtract of the doubled remainder in every stage
  always_comb begin
    for (int i = 1; i <= PB; i++) begin
      dbl[i]   = {rem_q[i-1], 1'b0};
      dif[i]   = dbl[i] - {1'b0, duration_i};
      ge[i]    = (dbl[i] >= {1'b0, duration_i});
      rem_d[i] = ge[i] ? dif[i][TB-1:0] : dbl[i][TB-1:0];
      quo_d[i] = {quo_q[i-1][PB-2:0], ge[i]};
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= PB; i++) vld_q[i] <= 1'b0;
    end else begin
      vld_q[0] <= in_valid_i;
      for (int i = 1; i <= PB; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  // Advance remainder, quotient and payload
  always_ff @(posedge clk_i) begin
    rem_q[0] <= elapsed_i;
    quo_q[0] <= '0;
    itm_q[0] <= item_i;
    for (int i = 1; i <= PB; i++) begin
      rem_q[i] <= rem_d[i];
      quo_q[i] <= quo_d[i];
      itm_q[i] <= itm_q[i-1];
    end
  end

  assign out_valid_o = vld_q[PB];
  assign p_o         = quo_q[PB];
  assign item_o      = itm_q[PB];

endmodule

`default_nettype wire

FILE: hw/rtl/eci_curve.sv
// Curve pipeline: evaluates every easing curve in parallel and selects the
// eased progress by mode. Depends on eci_pkg.
`default_nettype none

module eci_curve (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  input  wire logic [eci_pkg::PBITS-1:0] p_i,
  input  wire eci_pkg::item_t           item_i,
  input  wire eci_pkg::mode_e           mode_i,
  output logic                          out_valid_o,
  output eci_pkg::fx_t                  f_o,
  output eci_pkg::item_t                item_o
);

  localparam int unsigned PB = eci_pkg::PBITS;
  localparam int unsigned NS = eci_pkg::CV_STAGES;
  localparam int unsigned FW = eci_pkg::FX_W;

  // Back overshoot 1.70158 and 2.70158 in Q16, ln 2 in Q16
  localparam eci_pkg::fx_t BACK_S  = eci_pkg::fx_t'(111515);
  localparam eci_pkg::fx_t BACK_S1 = eci_pkg::fx_t'(177051);
  localparam eci_pkg::fx_t LN2     = eci_pkg::fx_t'(45426);
  localparam eci_pkg::fx_t TWO     = eci_pkg::fx_t'(131072);

  // 2^-r polynomial coefficients
  localparam eci_pkg::fx_t E7 = eci_pkg::fx_t'(13);
  localparam eci_pkg::fx_t E6 = eci_pkg::fx_t'(91);
  localparam eci_pkg::fx_t E5 = eci_pkg::fx_t'(546);
  localparam eci_pkg::fx_t E4 = eci_pkg::fx_t'(2731);
  localparam eci_pkg::fx_t E3 = eci_pkg::fx_t'(10923);
  localparam eci_pkg::fx_t E2 = eci_pkg::fx_t'(32768);
  // Sine polynomial coefficients
  localparam eci_pkg::fx_t S4 = eci_pkg::fx_t'(11);
  localparam eci_pkg::fx_t S3 = eci_pkg::fx_t'(307);
  localparam eci_pkg::fx_t S2 = eci_pkg::fx_t'(5223);
  localparam eci_pkg::fx_t S1 = eci_pkg::fx_t'(42334);
  localparam eci_pkg::fx_t S0 = eci_pkg::fx_t'(102944);

  // Phase: (10p + 2.25) / 3 via reciprocal ceil(2^21 / 3)
  localparam logic [19:0] PH_OFS   = 20'd147456;
  localparam logic [39:0] PH_RECIP = 40'd699051;

  typedef enum logic [1:0] {
    BNC_RISE,
    BNC_HOP1,
    BNC_HOP2,
    BNC_HOP3
  } bnc_e;

  typedef struct packed {
    logic [PB-1:0]        p;
    logic [3:0]           k;
    eci_pkg::fx_t         y;
    logic [PB-1:0]        ph;
    eci_pkg::fx_t         q;
    logic                 neg;
    eci_pkg::fx_t         q2;
    eci_pkg::fx_t         ea;
    eci_pkg::fx_t         sa;
    eci_pkg::fx_t         sn;
    logic signed [20:0]   w;
    bnc_e                 bsel;
    logic [35:0]          sq;
    eci_pkg::fx_t         fa;
    eci_pkg::fx_t         fb;
    eci_pkg::fx_t         fc;
    eci_pkg::fx_t         fe;
    eci_pkg::fx_t         sp;
    eci_pkg::fx_t         uu;
    eci_pkg::fx_t         su;
    eci_pkg::fx_t         bi;
    eci_pkg::fx_t         bo;
    eci_pkg::item_t       item;
  } cv_t;

  cv_t                 st_q [1:NS];
  cv_t                 st_d [1:NS];
  logic                vld_q [1:NS];
  logic                ov_q;
  eci_pkg::fx_t        f_q;
  eci_pkg::item_t      itm_q;
  eci_pkg::fx_t        f_sel;

  eci_pkg::fx_t        p_fx;
  eci_pkg::fx_t        u_fx;
  logic [PB+3:0]       e10;
  logic [PB+3:0]       e11;
  logic [19:0]         ph_x;
  logic [39:0]         ph_prod;
  logic signed [21:0]  e11s;
  logic signed [21:0]  w22;
  eci_pkg::fx_t        qraw;
  logic signed [41:0]  sqp;
  logic [36:0]         sq_r;
  logic [16:0]         bsh;
  eci_pkg::fx_t        boff;
  eci_pkg::fx_t        rnd;

  always_comb begin
    // Stage 1: scale progress, phase, bounce segment, first products
    p_fx    = {{(FW-PB){1'b0}}, p_i};
    u_fx    = p_fx - eci_pkg::Q_ONE;
    e10     = ({4'b0, p_i} << 3) + ({4'b0, p_i} << 1);
    e11     = e10 + {4'b0, p_i};
    ph_x    = e10 + PH_OFS;
    ph_prod = {20'b0, ph_x} * PH_RECIP;
    e11s    = $signed({2'b0, e11});

    st_d[1]      = '0;
    st_d[1].item = item_i;
    st_d[1].p    = p_i;
    st_d[1].k    = e10[PB+3:PB];
    st_d[1].y    = eci_pkg::mulq({{(FW-PB){1'b0}}, e10[PB-1:0]}, LN2);
    st_d[1].ph   = ph_prod[36:21];
    if (e11 < 20'd262144) begin
      st_d[1].bsel = BNC_RISE;
      w22 = e11s;
    end else if (e11 < 20'd524288) begin
      st_d[1].bsel = BNC_HOP1;
      w22 = e11s - 22'sd393216;
    end else if (e11 < 20'd655360) begin
      st_d[1].bsel = BNC_HOP2;
      w22 = e11s - 22'sd589824;
    end else begin
      st_d[1].bsel = BNC_HOP3;
      w22 = (e11s <<< 1) - 22'sd1376256;
    end
    st_d[1].w  = w22[20:0];
    st_d[1].fa = eci_pkg::mulq(p_fx, p_fx);
    st_d[1].fb = eci_pkg::mulq(p_fx, TWO - p_fx);
    st_d[1].sp = eci_pkg::mulq(BACK_S1, p_fx) - BACK_S;
    st_d[1].uu = eci_pkg::mulq(u_fx, u_fx);
    st_d[1].su = eci_pkg::mulq(BACK_S1, u_fx) + BACK_S;

    // Stage 2: fold phase to quarter wave, square terms, back products
    st_d[2]     = st_q[1];
    qraw        = {{(FW-16){1'b0}}, st_q[1].ph[13:0], 2'b00};
    st_d[2].q   = st_q[1].ph[14] ? (eci_pkg::Q_ONE - qraw) : qraw;
    st_d[2].neg = st_q[1].ph[15];
    st_d[2].q2  = eci_pkg::mulq(st_d[2].q, st_d[2].q);
    st_d[2].ea  = E6 - eci_pkg::mulq(st_q[1].y, E7);
    sqp         = st_q[1].w * st_q[1].w;
    st_d[2].sq  = sqp[35:0];
    st_d[2].bi  = eci_pkg::mulq(st_q[1].fa, st_q[1].sp);
    st_d[2].bo  = eci_pkg::mulq(st_q[1].uu, st_q[1].su) + eci_pkg::Q_ONE;

    // Stage 3: bounce rounding and offset, polynomials continue
    st_d[3]    = st_q[2];
    st_d[3].ea = E5 - eci_pkg::mulq(st_q[2].y, st_q[2].ea);
    st_d[3].sa = S3 - eci_pkg::mulq(st_q[2].q2, S4);
    if (st_q[2].bsel == BNC_HOP3) begin
      sq_r = {1'b0, st_q[2].sq} + 37'd2097152;
      bsh  = {2'b00, sq_r[36:22]};
    end else begin
      sq_r = {1'b0, st_q[2].sq} + 37'd524288;
      bsh  = sq_r[36:20];
    end
    unique case (st_q[2].bsel)
      BNC_RISE: boff = '0;
      BNC_HOP1: boff = eci_pkg::fx_t'(49152);
      BNC_HOP2: boff = eci_pkg::fx_t'(61440);
      BNC_HOP3: boff = eci_pkg::fx_t'(64512);
      default:  boff = '0;
    endcase
    st_d[3].fc = {{(FW-17){1'b0}}, bsh} + boff;

    // Stages 4 to 6: Horner steps
    st_d[4]    = st_q[3];
    st_d[4].ea = E4 - eci_pkg::mulq(st_q[3].y, st_q[3].ea);
    st_d[4].sa = S2 - eci_pkg::mulq(st_q[3].q2, st_q[3].sa);
    st_d[5]    = st_q[4];
    st_d[5].ea = E3 - eci_pkg::mulq(st_q[4].y, st_q[4].ea);
    st_d[5].sa = S1 - eci_pkg::mulq(st_q[4].q2, st_q[4].sa);
    st_d[6]    = st_q[5];
    st_d[6].ea = E2 - eci_pkg::mulq(st_q[5].y, st_q[5].ea);
    st_d[6].sa = S0 - eci_pkg::mulq(st_q[5].q2, st_q[5].sa);

    // Stage 7: last sine product, exponential step continues
    st_d[7]    = st_q[6];
    st_d[7].ea = eci_pkg::Q_ONE - eci_pkg::mulq(st_q[6].y, st_q[6].ea);
    st_d[7].sn = eci_pkg::mulq(st_q[6].q, st_q[6].sa);

    // Stage 8: last exponential step, sine sign
    st_d[8]    = st_q[7];
    st_d[8].ea = eci_pkg::Q_ONE - eci_pkg::mulq(st_q[7].y, st_q[7].ea);
    st_d[8].sn = st_q[7].neg ? -st_q[7].sn : st_q[7].sn;

    // Stage 9: scale by the integer power of two, rounded
    st_d[9] = st_q[8];
    rnd     = eci_pkg::fx_t'(1) << (st_q[8].k - 4'd1);
    if (st_q[8].k == 4'd0) begin
      st_d[9].ea = st_q[8].ea;
    end else begin
      st_d[9].ea = (st_q[8].ea + rnd) >>> st_q[8].k;
    end

    // Stage 10: elastic result
    st_d[10] = st_q[9];
    if (st_q[9].p == '0) begin
      st_d[10].fe = '0;
    end else begin
      st_d[10].fe = eci_pkg::Q_ONE + eci_pkg::mulq(st_q[9].ea, st_q[9].sn);
    end

    // Select eased progress; end reached forces one
    if (st_q[NS].item.fin) begin
      f_sel = eci_pkg::Q_ONE;
    end else begin
      unique case (mode_i)
        eci_pkg::MODE_LINEAR:   f_sel = {{(FW-PB){1'b0}}, st_q[NS].p};
        eci_pkg::MODE_QUAD_IN:  f_sel = st_q[NS].fa;
        eci_pkg::MODE_QUAD_OUT: f_sel = st_q[NS].fb;
        eci_pkg::MODE_BOUNCE:   f_sel = st_q[NS].fc;
        eci_pkg::MODE_ELASTIC:  f_sel = st_q[NS].fe;
        eci_pkg::MODE_BACK_IN:  f_sel = st_q[NS].bi;
        eci_pkg::MODE_BACK_OUT: f_sel = st_q[NS].bo;
        eci_pkg::MODE_UNKNOWN:  f_sel = eci_pkg::Q_ONE;
        default:                f_sel = eci_pkg::Q_ONE;
      endcase
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 1; i <= NS; i++) vld_q[i] <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      vld_q[1] <= in_valid_i;
      for (int i = 2; i <= NS; i++) vld_q[i] <= vld_q[i-1];
      ov_q <= vld_q[NS];
    end
  end

  // Advance stage data
  always_ff @(posedge clk_i) begin
    for (int i = 1; i <= NS; i++) st_q[i] <= st_d[i];
    f_q   <= f_sel;
    itm_q <= st_q[NS].item;
  end

  assign out_valid_o = ov_q;
  assign f_o         = f_q;
  assign item_o      = itm_q;

endmodule

`default_nettype wire

FILE: hw/rtl/eci_blend.sv
// Blend stages: start + change * eased progress, rounded and saturated to
// the value range. Depends on eci_pkg.
`default_nettype none

module eci_blend (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  input  wire eci_pkg::fx_t                        f_i,
  input  wire eci_pkg::item_t                      item_i,
  output logic                                     out_valid_o,
  output logic signed [eci_pkg::VALUE_BITS-1:0]    value_o,
  output logic                                     fin_o
);

  localparam int unsigned VB = eci_pkg::VALUE_BITS;
  localparam int unsigned FW = eci_pkg::FX_W;

  localparam logic signed [VB+16:0] RND  = (VB+17)'(32768);
  localparam logic signed [VB+9:0]  VMAX = (VB+10)'({1'b0, {(VB-1){1'b1}}});
  localparam logic signed [VB+9:0]  VMIN = -VMAX - (VB+10)'(1);

  logic signed [FW-17:0]   fi;
  logic signed [VB+7:0]    pi_d, pi_q;
  logic signed [VB+16:0]   pf_d, pf_q, pf_r;
  logic signed [VB-1:0]    start_q;
  logic                    fin_a_q, va_q, vb_q, fin_b_q;
  logic signed [VB:0]      sh;
  logic signed [VB+9:0]    sum;
  logic signed [VB-1:0]    sat;
  logic signed [VB-1:0]    val_q;

  // Integer and fraction products of change
  always_comb begin
    fi   = f_i[FW-1:16];
    pi_d = item_i.change * fi;
    pf_d = item_i.change * $signed({1'b0, f_i[15:0]});
  end

  // Round, add and saturate
  always_comb begin
    pf_r = pf_q + RND;
    sh   = pf_r[VB+16:16];
    sum  = start_q + pi_q + sh;
    if (sum > VMAX) begin
      sat = VMAX[VB-1:0];
    end else if (sum < VMIN) begin
      sat = VMIN[VB-1:0];
    end else begin
      sat = sum[VB-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      va_q <= in_valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pi_q    <= pi_d;
    pf_q    <= pf_d;
    start_q <= item_i.start;
    fin_a_q <= item_i.fin;
    val_q   <= sat;
    fin_b_q <= fin_a_q;
  end

  assign out_valid_o = vb_q;
  assign value_o     = val_q;
  assign fin_o       = fin_b_q;

endmodule

`default_nettype wire

FILE: hw/rtl/easing_curve_interpolator_unit.sv
// Top level of the easing curve interpolator: configuration registers and
// the divider, curve and blend pipelines. Depends on eci_pkg and submodules.
//
// The unit takes one item per clock: busy_o stays low, and an item is
// transferred whenever start_i is high. Its result appears on done_o,
// eased_value_o and finished_o for one cycle, and cannot be held off by
// the receiver. It passes through the launch register, the 16-stage
// restoring divider that forms the progress (one quotient bit per stage),
// the 10-stage curve pipeline set by the elastic 2^-x polynomial chain
// plus its select register, and two blend stages.
// Write ease_mode and duration only while no item is in flight.
`default_nettype none

module easing_curve_interpolator_unit (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start_i,
  output logic                                      busy_o,
  input  wire logic signed [eci_pkg::VALUE_BITS-1:0] start_value_i,
  input  wire logic signed [eci_pkg::VALUE_BITS-1:0] change_value_i,
  input  wire logic [eci_pkg::TIME_BITS-1:0]        elapsed_i,
  input  wire logic                                 cfg_we_i,
  input  wire logic [eci_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire logic [eci_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  output logic                                      done_o,
  output logic signed [eci_pkg::VALUE_BITS-1:0]     eased_value_o,
  output logic                                      finished_o
);

  eci_pkg::mode_e                   mode_q;
  logic [eci_pkg::TIME_BITS-1:0]    dur_q;
  logic                             accept;
  eci_pkg::item_t                   item_in;
  logic                             dv_valid;
  logic [eci_pkg::PBITS-1:0]        dv_p;
  eci_pkg::item_t                   dv_item;
  logic                             cv_valid;
  eci_pkg::fx_t                     cv_f;
  eci_pkg::item_t                   cv_item;

  // Hold configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= eci_pkg::MODE_LINEAR;
      dur_q  <= eci_pkg::TIME_BITS'(1000);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == eci_pkg::CFG_MODE) begin
        mode_q <= eci_pkg::mode_e'(cfg_data_i[2:0]);
      end else if (cfg_idx_i == eci_pkg::CFG_DURATION) begin
        dur_q <= cfg_data_i[eci_pkg::TIME_BITS-1:0];
      end
    end
  end

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  always_comb begin
    item_in.start  = start_value_i;
    item_in.change = change_value_i;
    item_in.fin    = (elapsed_i >= dur_q);
  end

  eci_divider u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (accept),
    .elapsed_i   (elapsed_i),
    .duration_i  (dur_q),
    .item_i      (item_in),
    .out_valid_o (dv_valid),
    .p_o         (dv_p),
    .item_o      (dv_item)
  );

  eci_curve u_curve (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (dv_valid),
    .p_i         (dv_p),
    .item_i      (dv_item),
    .mode_i      (mode_q),
    .out_valid_o (cv_valid),
    .f_o         (cv_f),
    .item_o      (cv_item)
  );

  eci_blend u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cv_valid),
    .f_i         (cv_f),
    .item_i      (cv_item),
    .out_valid_o (done_o),
    .value_o     (eased_value_o),
    .fin_o       (finished_o)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/eci_checker.sv
// Port-level checker for the easing curve interpolator, bound to the top
// level. Depends on eci_pkg.
`default_nettype none

module eci_checker (
  input wire logic                                 clk_i,
  input wire logic                                 rst_ni,
  input wire logic                                 start_i,
  input wire logic                                 busy_o,
  input wire logic signed [eci_pkg::VALUE_BITS-1:0] start_value_i,
  input wire logic signed [eci_pkg::VALUE_BITS-1:0] change_value_i,
  input wire logic [eci_pkg::TIME_BITS-1:0]        elapsed_i,
  input wire logic                                 cfg_we_i,
  input wire logic [eci_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input wire logic [eci_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input wire logic                                 done_o,
  input wire logic signed [eci_pkg::VALUE_BITS-1:0] eased_value_o,
  input wire logic                                 finished_o
);

  // Every transfer yields a result after the fixed latency
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##(eci_pkg::PIPE_DEPTH) done_o)
    else $error("transfer produced no result");

  // No result without a transfer
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start_i && !busy_o) |-> ##(eci_pkg::PIPE_DEPTH) !done_o)
    else $error("result without transfer");

  // Largest elapsed time always ends the tween
  a_end_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && elapsed_i == '1)
      |-> ##(eci_pkg::PIPE_DEPTH) (done_o && finished_o))
    else $error("finished flag missing at end of tween");

endmodule

bind easing_curve_interpolator_unit eci_checker u_eci_checker (.*);

`default_nettype wire
